@@ design/sssp_pkg.sv @@
// Shared types and constants for the shortest-path core.
// Used by the core and the relaxation unit; depends on nothing else.
`default_nettype none

package sssp_pkg;

	// Widths of the request and result fields.
	localparam int REQ_W          = 2;
	localparam int NODE_FIELD_W   = 6;
	localparam int WEIGHT_FIELD_W = 16;
	localparam int DIST_W         = 22;
	localparam int CFG_DATA_W     = 7;
	localparam int CFG_IDX_W      = 1;

	// Default sizing of the core.
	localparam int MAX_NODES_DEF   = 64;
	localparam int WEIGHT_BITS_DEF = 16;

	// Largest distance; longer sums saturate here.
	localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

	// Reset values of the configuration registers.
	localparam logic [CFG_DATA_W-1:0]   NODE_COUNT_RESET = 7'd64;
	localparam logic [NODE_FIELD_W-1:0] SOURCE_RESET     = 6'd0;

	// Request codes.
	localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd0;
	localparam logic [REQ_W-1:0] REQ_EDGE  = 2'd1;
	localparam logic [REQ_W-1:0] REQ_SOLVE = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SOURCE     = 1'd1;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EDGE_AB,
		ST_EDGE_BA,
		ST_SOLVE,
		ST_RELAX,
		ST_EMIT
	} state_t;

	// Verdict of the relaxation unit for one neighbor.
	typedef struct packed {
		logic              write;      // store value as the node's new distance
		logic              reached;    // node is reached after this step
		logic              candidate;  // node is the nearest open node so far
		logic [DIST_W-1:0] value;      // node's distance after this step
	} relax_res_t;

endpackage

`default_nettype wire

@@ design/single_source_shortest_path_core.sv @@
// Shortest-path core: Dijkstra over a stored adjacency matrix, one node a cycle.
// Clear: a sweep writes all MAX_NODES*MAX_NODES entries, and also runs after reset.
// Add edge: A to B is written, then B to A. Solve: the source is set, one relaxation
// pass over the N nodes in use runs per reached node, then an emission pass; results
// leave one per cycle and cannot be held off. Throughput is set by the single
// relaxation unit and the one adjacency read port. Reset is asynchronous, active low.
`default_nettype none

module single_source_shortest_path_core #(
	parameter int MAX_NODES   = sssp_pkg::MAX_NODES_DEF,
	parameter int WEIGHT_BITS = sssp_pkg::WEIGHT_BITS_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	// Request channel.
	input  wire logic                                 start,
	output      logic                                 busy,
	input  wire logic [sssp_pkg::REQ_W-1:0]           req_type,
	input  wire logic [sssp_pkg::NODE_FIELD_W-1:0]    node_a,
	input  wire logic [sssp_pkg::NODE_FIELD_W-1:0]    node_b,
	input  wire logic [sssp_pkg::WEIGHT_FIELD_W-1:0]  weight,
	// Configuration write port.
	input  wire logic                                 cfg_we,
	input  wire logic [sssp_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [sssp_pkg::CFG_DATA_W-1:0]      cfg_data,
	// Result channel.
	output      logic                                 result_valid,
	output      logic [sssp_pkg::NODE_FIELD_W-1:0]    node,
	output      logic [sssp_pkg::DIST_W-1:0]          distance,
	output      logic                                 reachable,
	output      logic                                 last
);

	localparam int NODE_W = $clog2(MAX_NODES);
	localparam int CNT_W  = $clog2(MAX_NODES + 1);
	localparam int DEPTH  = MAX_NODES * MAX_NODES;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int EDGE_W = WEIGHT_BITS + 1;
	localparam int DW     = sssp_pkg::DIST_W;
	localparam int NFW    = sssp_pkg::NODE_FIELD_W;
	localparam int CDW    = sssp_pkg::CFG_DATA_W;
	localparam int WFW    = sssp_pkg::WEIGHT_FIELD_W;
	localparam int WEXT_W = (WEIGHT_BITS > WFW) ? WEIGHT_BITS : WFW;

	// Configuration registers.
	logic [CDW-1:0] node_count_q;
	logic [NFW-1:0] source_q;

	// Sequencer state.
	sssp_pkg::state_t state_q, state_d;
	logic [ADDR_W-1:0] clr_q;
	logic [CNT_W-1:0]  i_q;

	// Latched request fields for the edge writes.
	logic [NFW-1:0]                      node_a_q, node_b_q;
	logic [sssp_pkg::WEIGHT_FIELD_W-1:0] weight_q;

	// Solver state: current node, its distance, the running minimum of the pass.
	logic [NODE_W-1:0]    k_q, kn_q;
	logic [DW-1:0]        bestk_q, min_q;
	logic                 found_q;
	logic [MAX_NODES-1:0] reached_q, finished_q;

	// Read pipeline stage.
	logic              valid_s1;
	logic [NODE_W-1:0] idx_s1;

	// Result registers.
	logic           result_valid_q;
	logic [NFW-1:0] node_q;
	logic [DW-1:0]  distance_q;
	logic           reachable_q, last_q;

	// Memory ports.
	logic              adj_we;
	logic [ADDR_W-1:0] adj_waddr, adj_raddr;
	logic [EDGE_W-1:0] adj_wdata, adj_rdata;
	logic              best_we;
	logic [NODE_W-1:0] best_waddr;
	logic [DW-1:0]     best_wdata, best_rdata;

	// Derived control.
	logic                 accept;
	logic [CNT_W-1:0]     cnt;
	logic                 src_ok;
	logic [MAX_NODES-1:0] src_onehot;
	logic                 in_range;
	logic                 issue;
	logic                 last_s1;
	logic                 pass_end;
	logic [WEXT_W-1:0]    weight_ext;
	logic [EDGE_W-1:0]    edge_word;
	sssp_pkg::relax_res_t res;
	logic                 found_d;
	logic [DW-1:0]        min_d;
	logic [NODE_W-1:0]    kn_d;

	assign busy   = (state_q != sssp_pkg::ST_IDLE);
	assign accept = start && !busy;

	// The node count register saturates into the range one to MAX_NODES.
	always_comb begin
		if (node_count_q == '0) begin
			cnt = CNT_W'(1);
		end else if (node_count_q > CDW'(MAX_NODES)) begin
			cnt = CNT_W'(MAX_NODES);
		end else begin
			cnt = CNT_W'(node_count_q);
		end
	end

	// A source outside the nodes in use leaves every node unreachable.
	assign src_ok   = (CDW'(source_q) < CDW'(cnt));
	assign in_range = (CDW'(node_a) < CDW'(MAX_NODES)) && (CDW'(node_b) < CDW'(MAX_NODES));

	// At solve start only the source is reached and finished.
	assign src_onehot = src_ok ? (MAX_NODES'(1) << source_q[NODE_W-1:0]) : '0;

	// One node index is issued to the memories per cycle during a pass.
	assign issue    = (i_q < cnt);
	assign last_s1  = ((CNT_W'(idx_s1) + CNT_W'(1)) == cnt);
	assign pass_end = valid_s1 && last_s1;

	// Weights wider than the request field are zero extended.
	assign weight_ext = WEXT_W'(weight_q);
	assign edge_word  = {1'b1, weight_ext[WEIGHT_BITS-1:0]};

	sssp_relax #(
		.WEIGHT_BITS(WEIGHT_BITS)
	) u_relax (
		.edge_word  (adj_rdata),
		.best_k     (bestk_q),
		.best_old   (best_rdata),
		.is_reached (reached_q[idx_s1]),
		.is_finished(finished_q[idx_s1]),
		.found      (found_q),
		.min_dist   (min_q),
		.res        (res)
	);

	// The nearest open node of the next round is found during this relaxation pass,
	// since every node's final distance for this round is seen exactly once.
	assign found_d = found_q || res.candidate;
	assign min_d   = res.candidate ? res.value : min_q;
	assign kn_d    = res.candidate ? idx_s1 : kn_q;

	// Adjacency memory: written by the clear sweep and the two halves of an edge,
	// read along the row of the node being finished.
	always_comb begin
		adj_we    = 1'b0;
		adj_waddr = clr_q;
		adj_wdata = '0;
		unique case (state_q)
			sssp_pkg::ST_CLEAR: begin
				adj_we = 1'b1;
			end
			sssp_pkg::ST_EDGE_AB: begin
				adj_we    = 1'b1;
				adj_waddr = ADDR_W'(node_a_q[NODE_W-1:0]) * ADDR_W'(MAX_NODES)
					+ ADDR_W'(node_b_q[NODE_W-1:0]);
				adj_wdata = edge_word;
			end
			sssp_pkg::ST_EDGE_BA: begin
				adj_we    = 1'b1;
				adj_waddr = ADDR_W'(node_b_q[NODE_W-1:0]) * ADDR_W'(MAX_NODES)
					+ ADDR_W'(node_a_q[NODE_W-1:0]);
				adj_wdata = edge_word;
			end
			default: begin
				adj_we = 1'b0;
			end
		endcase
	end

	assign adj_raddr = ADDR_W'(k_q) * ADDR_W'(MAX_NODES) + ADDR_W'(i_q[NODE_W-1:0]);

	// Distance table: the source is set to zero at solve start, and improved
	// distances are written back during relaxation.
	assign best_we = ((state_q == sssp_pkg::ST_SOLVE) && src_ok)
		|| ((state_q == sssp_pkg::ST_RELAX) && valid_s1 && res.write);
	assign best_waddr = (state_q == sssp_pkg::ST_SOLVE) ? source_q[NODE_W-1:0] : idx_s1;
	assign best_wdata = (state_q == sssp_pkg::ST_SOLVE) ? '0 : res.value;

	sssp_ram #(
		.WIDTH(EDGE_W),
		.DEPTH(DEPTH)
	) u_adj_ram (
		.clk  (clk),
		.we   (adj_we),
		.waddr(adj_waddr),
		.wdata(adj_wdata),
		.raddr(adj_raddr),
		.rdata(adj_rdata)
	);

	sssp_ram #(
		.WIDTH(DW),
		.DEPTH(MAX_NODES)
	) u_best_ram (
		.clk  (clk),
		.we   (best_we),
		.waddr(best_waddr),
		.wdata(best_wdata),
		.raddr(i_q[NODE_W-1:0]),
		.rdata(best_rdata)
	);

	// Next-state logic of the sequencer.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sssp_pkg::ST_CLEAR: begin
				if (clr_q == ADDR_W'(DEPTH - 1)) begin
					state_d = sssp_pkg::ST_IDLE;
				end
			end
			sssp_pkg::ST_IDLE: begin
				if (accept) begin
					unique case (req_type)
						sssp_pkg::REQ_CLEAR: state_d = sssp_pkg::ST_CLEAR;
						sssp_pkg::REQ_EDGE:
							state_d = in_range ? sssp_pkg::ST_EDGE_AB : sssp_pkg::ST_IDLE;
						sssp_pkg::REQ_SOLVE: state_d = sssp_pkg::ST_SOLVE;
						default: state_d = sssp_pkg::ST_IDLE;
					endcase
				end
			end
			sssp_pkg::ST_EDGE_AB: begin
				state_d = sssp_pkg::ST_EDGE_BA;
			end
			sssp_pkg::ST_EDGE_BA: begin
				state_d = sssp_pkg::ST_IDLE;
			end
			sssp_pkg::ST_SOLVE: begin
				state_d = src_ok ? sssp_pkg::ST_RELAX : sssp_pkg::ST_EMIT;
			end
			sssp_pkg::ST_RELAX: begin
				if (pass_end) begin
					state_d = found_d ? sssp_pkg::ST_RELAX : sssp_pkg::ST_EMIT;
				end
			end
			sssp_pkg::ST_EMIT: begin
				if (pass_end) begin
					state_d = sssp_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = sssp_pkg::ST_IDLE;
			end
		endcase
	end

	// State register; reset starts with a sweep that empties the matrix.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sssp_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q   <= sssp_pkg::NODE_COUNT_RESET;
			source_q       <= sssp_pkg::SOURCE_RESET;
			clr_q          <= '0;
			i_q            <= '0;
			valid_s1       <= 1'b0;
			found_q        <= 1'b0;
			reached_q      <= '0;
			finished_q     <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == sssp_pkg::CFG_NODE_COUNT) begin
					node_count_q <= cfg_data;
				end else if (cfg_index == sssp_pkg::CFG_SOURCE) begin
					source_q <= cfg_data[NFW-1:0];
				end
			end

			if (state_q == sssp_pkg::ST_CLEAR) begin
				clr_q <= clr_q + ADDR_W'(1);
			end else begin
				clr_q <= '0;
			end

			// Index counter: restarts at the end of every pass.
			if ((state_q == sssp_pkg::ST_RELAX) || (state_q == sssp_pkg::ST_EMIT)) begin
				if (pass_end) begin
					i_q <= '0;
				end else if (issue) begin
					i_q <= i_q + CNT_W'(1);
				end
			end else begin
				i_q <= '0;
			end
			valid_s1 <= ((state_q == sssp_pkg::ST_RELAX) || (state_q == sssp_pkg::ST_EMIT))
				&& issue;

			if (state_q == sssp_pkg::ST_SOLVE) begin
				found_q    <= 1'b0;
				reached_q  <= src_onehot;
				finished_q <= src_onehot;
			end else if ((state_q == sssp_pkg::ST_RELAX) && valid_s1) begin
				found_q <= pass_end ? 1'b0 : found_d;
				reached_q[idx_s1] <= res.reached;
				if (pass_end && found_d) begin
					finished_q[kn_d] <= 1'b1;
				end
			end

			result_valid_q <= (state_q == sssp_pkg::ST_EMIT) && valid_s1;
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			node_a_q <= node_a;
			node_b_q <= node_b;
			weight_q <= weight;
		end
		idx_s1 <= i_q[NODE_W-1:0];
		if (state_q == sssp_pkg::ST_SOLVE) begin
			k_q     <= source_q[NODE_W-1:0];
			bestk_q <= '0;
		end else if ((state_q == sssp_pkg::ST_RELAX) && valid_s1) begin
			min_q <= min_d;
			kn_q  <= kn_d;
			if (pass_end && found_d) begin
				k_q     <= kn_d;
				bestk_q <= min_d;
			end
		end
		if ((state_q == sssp_pkg::ST_EMIT) && valid_s1) begin
			node_q      <= NFW'(idx_s1);
			distance_q  <= reached_q[idx_s1] ? best_rdata : '0;
			reachable_q <= reached_q[idx_s1];
			last_q      <= last_s1;
		end
	end

	assign result_valid = result_valid_q;
	assign node         = node_q;
	assign distance     = distance_q;
	assign reachable    = reachable_q;
	assign last         = last_q;

	// A result is only ever produced out of the emission pass.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(state_q == sssp_pkg::ST_EMIT))
		else $error("result outside the emission pass");

	// The final result of a solve coincides with the core becoming free.
	assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && last) |-> !busy)
		else $error("core still busy on the last result");

	// Every finished node must have been reached.
	assert property (@(posedge clk) disable iff (!arst_n)
		(finished_q & ~reached_q) == '0)
		else $error("finished node that was never reached");

	// An accepted solve request keeps the core busy on the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (req_type == sssp_pkg::REQ_SOLVE)) |=> busy)
		else $error("solve request did not start");

endmodule

`default_nettype wire

@@ design/sssp_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Standalone; holds the adjacency matrix and the distance table.
`default_nettype none

module sssp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

@@ design/sssp_relax.sv @@
// Shared relaxation unit: one saturating add and the distance compares.
// Depends on sssp_pkg for the distance width and the result struct.
`default_nettype none

module sssp_relax #(
	parameter int WEIGHT_BITS = sssp_pkg::WEIGHT_BITS_DEF
) (
	input  wire logic [WEIGHT_BITS:0]         edge_word,
	input  wire logic [sssp_pkg::DIST_W-1:0]  best_k,
	input  wire logic [sssp_pkg::DIST_W-1:0]  best_old,
	input  wire logic                         is_reached,
	input  wire logic                         is_finished,
	input  wire logic                         found,
	input  wire logic [sssp_pkg::DIST_W-1:0]  min_dist,
	output      sssp_pkg::relax_res_t         res
);

	localparam int DW    = sssp_pkg::DIST_W;
	localparam int SUM_W = ((WEIGHT_BITS > DW) ? WEIGHT_BITS : DW) + 1;

	logic [SUM_W-1:0] sum;
	logic [DW-1:0]    sum_sat;
	logic             do_write;
	logic [DW-1:0]    value;
	logic             now_reached;

	always_comb begin
		sum = SUM_W'(best_k) + SUM_W'(edge_word[WEIGHT_BITS-1:0]);
		sum_sat = (sum > SUM_W'(sssp_pkg::DIST_MAX)) ? sssp_pkg::DIST_MAX : sum[DW-1:0];
		// A finished node is never revisited; an edge improves an unreached
		// node always and a reached one only when strictly shorter.
		do_write = !is_finished && edge_word[WEIGHT_BITS] &&
			(!is_reached || (sum_sat < best_old));
		value = do_write ? sum_sat : best_old;
		now_reached = is_reached || do_write;
		res.write = do_write;
		res.reached = now_reached;
		res.value = value;
		// Strict compare keeps the lowest index on a tie.
		res.candidate = !is_finished && now_reached && (!found || (value < min_dist));
	end

endmodule

`default_nettype wire

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for single_source_shortest_path_core: directed table, then random graphs.
// Expected distances come from a Dijkstra predictor kept inside this file.
// Depends on design/sssp_pkg.sv and design/single_source_shortest_path_core.sv.

module tb_top;
	import sssp_pkg::*;

	// Code of the one request value that the core must ignore.
	localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

	// Random requests after the directed table. Ignored requests do not count.
	localparam int RANDOM_REQUESTS = 110;
	// Quiet time before a register write. A clear can still be sweeping the matrix
	// after the last result has come, and a sweep visits MAX_NODES squared entries.
	localparam int SETTLE_CYCLES = MAX_NODES_DEF * MAX_NODES_DEF + 128;
	// Drain time at the end. This is longer than a full solve at 64 nodes, so a stray
	// result would still be seen.
	localparam int TAIL_CYCLES = 4600;
	// Watchdog. The slowest legal run is a few hundred full solves, plus settle time
	// and the reset sweep. This limit is several times that.
	localparam int CYCLE_LIMIT = 6000000;

	// One result of a solve, packed in port order.
	typedef struct packed {
		logic [NODE_FIELD_W-1:0] node;
		logic [DIST_W-1:0]       distance;
		logic                    reachable;
		logic                    last;
	} dist_result_t;

	// One row of the directed table. A row is either a register write or a request.
	// A request row may carry a typed-in result. Such a row is used only for
	// one-node solves, whose one result can be read off at a glance.
	typedef struct packed {
		logic                      is_reg;
		logic [CFG_IDX_W-1:0]      reg_idx;
		logic [CFG_DATA_W-1:0]     reg_val;
		logic [REQ_W-1:0]          kind;
		logic [NODE_FIELD_W-1:0]   a;
		logic [NODE_FIELD_W-1:0]   b;
		logic [WEIGHT_FIELD_W-1:0] w;
		logic                      typed;
		dist_result_t              want;
	} plan_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [REQ_W-1:0] req_type = REQ_CLEAR;
	logic [NODE_FIELD_W-1:0] node_a = '0;
	logic [NODE_FIELD_W-1:0] node_b = '0;
	logic [WEIGHT_FIELD_W-1:0] weight = '0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_NODE_COUNT;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	wire logic busy;
	wire logic result_valid;
	wire logic [NODE_FIELD_W-1:0] node;
	wire logic [DIST_W-1:0] distance;
	wire logic reachable;
	wire logic last;

	single_source_shortest_path_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.req_type     (req_type),
		.node_a       (node_a),
		.node_b       (node_b),
		.weight       (weight),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.result_valid (result_valid),
		.node         (node),
		.distance     (distance),
		.reachable    (reachable),
		.last         (last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Shadow of the core's state. The matrix holds a valid flag and a weight per
	// ordered pair. The two registers hold the values as they were last written.
	bit                        link_valid [MAX_NODES_DEF][MAX_NODES_DEF];
	logic [WEIGHT_FIELD_W-1:0] link_len   [MAX_NODES_DEF][MAX_NODES_DEF];
	logic [CFG_DATA_W-1:0]     cur_node_count = NODE_COUNT_RESET;
	logic [NODE_FIELD_W-1:0]   cur_source     = SOURCE_RESET;

	// Distances still owed by the core, oldest first.
	dist_result_t pending_distances [$];

	int mismatches = 0;
	int requests_done = 0;
	int cycle_count = 0;

	// A node count of zero behaves as one, and a count above the matrix size is clamped.
	function automatic int active_nodes();
		if (cur_node_count == 0)
			return 1;
		if (int'(cur_node_count) > MAX_NODES_DEF)
			return MAX_NODES_DEF;
		return int'(cur_node_count);
	endfunction

	// Dijkstra with a linear scan for the nearest open node. A tie goes to the
	// lowest index. Each node gets one result, in node order. A node with no path
	// reports distance zero with the reachable flag low. When the source lies
	// outside the active nodes, no node is reached.
	function automatic void queue_distances();
		int cnt;
		int k;
		int unsigned sum;
		logic [DIST_W-1:0] path_len [MAX_NODES_DEF];
		bit closed [MAX_NODES_DEF];
		bit hit [MAX_NODES_DEF];
		dist_result_t res;
		cnt = active_nodes();
		for (int i = 0; i < MAX_NODES_DEF; i++) begin
			path_len[i] = '0;
			closed[i] = 1'b0;
			hit[i] = 1'b0;
		end
		if (int'(cur_source) < cnt)
			hit[cur_source] = 1'b1;
		for (int r = 0; r < cnt; r++) begin
			k = cnt;
			for (int i = 0; i < cnt; i++)
				if (hit[i] && !closed[i] && (k == cnt || path_len[i] < path_len[k]))
					k = i;
			if (k == cnt)
				break;
			closed[k] = 1'b1;
			for (int i = 0; i < cnt; i++) begin
				if (!closed[i] && link_valid[k][i]) begin
					// With 16-bit weights the sum cannot really overflow 22 bits,
					// but the core saturates and so does this model.
					sum = path_len[k] + link_len[k][i];
					if (sum > DIST_MAX)
						sum = DIST_MAX;
					if (!hit[i] || sum < path_len[i]) begin
						path_len[i] = sum[DIST_W-1:0];
						hit[i] = 1'b1;
					end
				end
			end
		end
		for (int i = 0; i < cnt; i++) begin
			res.node = NODE_FIELD_W'(i);
			res.distance = hit[i] ? path_len[i] : '0;
			res.reachable = hit[i];
			res.last = (i == cnt - 1);
			pending_distances.push_back(res);
		end
	endfunction

	// Updates the shadow for one accepted request. A self loop is stored like any
	// other edge but never shortens a path. With all 16 weight bits in use, the
	// weight is stored whole.
	function automatic void apply_request(plan_row_t r);
		case (r.kind)
			REQ_CLEAR: begin
				foreach (link_valid[i, j])
					link_valid[i][j] = 1'b0;
			end
			REQ_EDGE: begin
				link_valid[r.a][r.b] = 1'b1;
				link_valid[r.b][r.a] = 1'b1;
				link_len[r.a][r.b] = r.w;
				link_len[r.b][r.a] = r.w;
			end
			REQ_SOLVE: queue_distances();
			default: ;
		endcase
	endfunction

	function automatic plan_row_t req_row(logic [REQ_W-1:0] kind, int a, int b, int w);
		plan_row_t r;
		r = '0;
		r.kind = kind;
		r.a = NODE_FIELD_W'(a);
		r.b = NODE_FIELD_W'(b);
		r.w = WEIGHT_FIELD_W'(w);
		return r;
	endfunction

	function automatic plan_row_t reg_row(logic [CFG_IDX_W-1:0] idx, int val);
		plan_row_t r;
		r = '0;
		r.is_reg = 1'b1;
		r.reg_idx = idx;
		r.reg_val = CFG_DATA_W'(val);
		return r;
	endfunction

	// Solve over a single active node: node 0, distance 0, last set. It is reached
	// only when the source is node 0.
	function automatic plan_row_t solo_row(logic reach);
		plan_row_t r;
		r = req_row(REQ_SOLVE, 0, 0, 0);
		r.typed = 1'b1;
		r.want = '{node: '0, distance: '0, reachable: reach, last: 1'b1};
		return r;
	endfunction

	// Directed part. It covers the reset state, node counts of zero, one, two, 64
	// and above 64, a source outside the active nodes, and a source written with the
	// spare data bit set. The graph rows cover weights of zero and all ones, a self
	// loop, an overwritten pair in reversed order, an edge to an inactive node, the
	// ignored request code, and a clear followed by a solve.
	localparam int PLAN_LEN = 31;
	plan_row_t directed_plan [PLAN_LEN] = '{
		req_row(REQ_SOLVE, 0, 0, 0),
		reg_row(CFG_NODE_COUNT, 1),
		solo_row(1'b1),
		reg_row(CFG_SOURCE, 5),
		solo_row(1'b0),
		reg_row(CFG_NODE_COUNT, 0),
		solo_row(1'b0),
		reg_row(CFG_SOURCE, 0),
		solo_row(1'b1),
		reg_row(CFG_NODE_COUNT, 127),
		reg_row(CFG_SOURCE, 127),
		req_row(REQ_EDGE, 63, 0, 16'hFFFF),
		req_row(REQ_EDGE, 63, 62, 0),
		req_row(REQ_EDGE, 62, 1, 1),
		req_row(REQ_EDGE, 0, 1, 7),
		req_row(REQ_EDGE, 5, 5, 3),
		req_row(REQ_EDGE, 1, 0, 100),
		req_row(REQ_UNUSED, 63, 63, 16'hFFFF),
		req_row(REQ_SOLVE, 0, 0, 0),
		reg_row(CFG_NODE_COUNT, 2),
		reg_row(CFG_SOURCE, 1),
		req_row(REQ_EDGE, 0, 40, 9),
		req_row(REQ_SOLVE, 0, 0, 0),
		req_row(REQ_CLEAR, 0, 0, 0),
		req_row(REQ_SOLVE, 0, 0, 0),
		reg_row(CFG_NODE_COUNT, 64),
		reg_row(CFG_SOURCE, 0),
		req_row(REQ_EDGE, 0, 63, 16'hAAAA),
		req_row(REQ_EDGE, 63, 32, 16'h5555),
		req_row(REQ_SOLVE, 63, 63, 16'hFFFF),
		req_row(REQ_CLEAR, 63, 63, 16'hFFFF)
	};

	// Drives one request from a falling edge and holds it until a rising edge sees
	// busy low. The shadow is updated at that edge. The task returns on the next
	// falling edge and leaves start high, so a following request can go out with no
	// gap.
	task automatic send(plan_row_t r);
		start <= 1'b1;
		req_type <= r.kind;
		node_a <= r.a;
		node_b <= r.b;
		weight <= r.w;
		do
			@(posedge clk);
		while (busy);
		if (r.typed)
			pending_distances.push_back(r.want);
		else
			apply_request(r);
		if (r.kind != REQ_UNUSED)
			requests_done++;
		@(negedge clk);
	endtask

	// Random idle cycles before a request. Each cycle idles with the given chance
	// in percent. The request fields carry junk while start is low.
	task automatic idle_gap(int pct);
		while ($urandom_range(99) < pct) begin
			start <= 1'b0;
			req_type <= REQ_W'($urandom_range(3));
			node_a <= NODE_FIELD_W'($urandom_range(63));
			node_b <= NODE_FIELD_W'($urandom_range(63));
			weight <= WEIGHT_FIELD_W'($urandom_range(65535));
			@(negedge clk);
		end
	endtask

	// Brings the core to rest before register writes. The sender holds off until
	// every owed result has arrived, then allows time for a clear sweep to finish.
	task automatic settle();
		start <= 1'b0;
		while (pending_distances.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// A register write lasts one cycle. The enable drops on the next falling edge,
	// so back-to-back writes never assign the enable twice in one time step.
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		if (idx == CFG_NODE_COUNT)
			cur_node_count = val;
		else
			cur_source = val[NODE_FIELD_W-1:0];
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// Edge endpoint. Most fall inside the active nodes, and a few range over the
	// whole matrix, so some edges go to nodes the solve does not use.
	function automatic int pick_node(int active);
		if ($urandom_range(9) == 0)
			return $urandom_range(63);
		return $urandom_range(active - 1);
	endfunction

	task automatic check_field(string what, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
		end
	endtask

	// Result side. The core cannot be stalled, so every strobe is a result that is
	// taken at this edge. It is checked against the oldest owed distance.
	always @(posedge clk) begin : result_check
		dist_result_t got;
		dist_result_t want;
		if (arst_n && result_valid) begin
			got = {node, distance, reachable, last};
			if (pending_distances.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected result, expected none, actual node %0d distance %0d",
					$time, got.node, got.distance);
			end else begin
				want = pending_distances.pop_front();
				check_field("node", 32'(want.node), 32'(got.node));
				check_field("distance", 32'(want.distance), 32'(got.distance));
				check_field("reachable", 32'(want.reachable), 32'(got.reachable));
				check_field("last", 32'(want.last), 32'(got.last));
			end
		end
	end

	// Watchdog. A hung handshake or a missing result ends the run here.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb_top NOT OK");
			$finish;
		end
	end

	initial begin : stimulus
		int random_base;
		int idle_pct;
		int active;
		int src;
		int edge_cnt;
		int w;
		int a;
		int prev_b;
		logic [CFG_DATA_W-1:0] count_val;
		bit prev_was_reg;

		foreach (link_valid[i, j]) begin
			link_valid[i][j] = 1'b0;
			link_len[i][j] = '0;
		end

		// Reset is asserted once, at the start. The core then sweeps its matrix and
		// keeps busy high meanwhile, so the first request simply waits.
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed table. A batch of register writes waits until the core is at rest.
		prev_was_reg = 1'b0;
		for (int i = 0; i < PLAN_LEN; i++) begin
			if (directed_plan[i].is_reg) begin
				if (!prev_was_reg)
					settle();
				write_reg(directed_plan[i].reg_idx, directed_plan[i].reg_val);
			end else begin
				idle_gap(14);
				send(directed_plan[i]);
			end
			prev_was_reg = directed_plan[i].is_reg;
		end

		// Random phases. Each phase waits for the core to go idle and writes both
		// registers. It then runs a few graphs: an optional clear, a burst of edges
		// that often chain into paths, and a solve. Stray ignored requests, solves on
		// an empty or stale graph, and repeated solves are mixed in. The sender idles
		// 14% of cycles in the first third, 87% in the second, and never in the last.
		random_base = requests_done;
		prev_b = 0;
		while (requests_done - random_base < RANDOM_REQUESTS) begin
			settle();
			case ($urandom_range(9))
				0: count_val = 7'd0;
				1: count_val = 7'd1;
				2: count_val = 7'd64;
				3: count_val = 7'd127;
				4: count_val = CFG_DATA_W'($urandom_range(65, 126));
				default: count_val = CFG_DATA_W'($urandom_range(2, 12));
			endcase
			write_reg(CFG_NODE_COUNT, count_val);
			active = active_nodes();
			// The source is usually an active node. Sometimes it may fall anywhere,
			// and then it is often outside the active nodes.
			case ($urandom_range(7))
				0: src = 63;
				1: src = $urandom_range(63);
				default: src = $urandom_range(active - 1);
			endcase
			write_reg(CFG_SOURCE, {1'($urandom_range(1)), NODE_FIELD_W'(src)});

			repeat ($urandom_range(1, 3)) begin
				if (requests_done - random_base < RANDOM_REQUESTS / 3)
					idle_pct = 14;
				else if (requests_done - random_base < 2 * RANDOM_REQUESTS / 3)
					idle_pct = 87;
				else
					idle_pct = 0;

				if ($urandom_range(3) == 0) begin
					idle_gap(idle_pct);
					send(req_row(REQ_CLEAR, $urandom_range(63), $urandom_range(63),
						$urandom_range(65535)));
				end

				edge_cnt = ($urandom_range(6) == 0) ? 0 :
					$urandom_range(1, (3 * active < 14) ? 3 * active : 14);
				repeat (edge_cnt) begin
					// Small weights give ties and competing paths. The extremes and
					// full-range values cover every weight bit.
					case ($urandom_range(9))
						0: w = 0;
						1: w = 16'hFFFF;
						2, 3: w = $urandom_range(65535);
						default: w = $urandom_range(1, 20);
					endcase
					a = $urandom_range(1) ? prev_b : pick_node(active);
					if ($urandom_range(19) == 0)
						prev_b = a;
					else
						prev_b = pick_node(active);
					idle_gap(idle_pct);
					send(req_row(REQ_EDGE, a, prev_b, w));
					if ($urandom_range(11) == 0) begin
						idle_gap(idle_pct);
						send(req_row(REQ_UNUSED, $urandom_range(63), $urandom_range(63),
							$urandom_range(65535)));
					end
				end

				idle_gap(idle_pct);
				send(req_row(REQ_SOLVE, $urandom_range(63), $urandom_range(63),
					$urandom_range(65535)));
				if ($urandom_range(7) == 0) begin
					idle_gap(idle_pct);
					send(req_row(REQ_SOLVE, 0, 0, 0));
				end
			end
		end

		// Wind down: wait until every owed distance has arrived, then watch a while
		// longer for stray results.
		start <= 1'b0;
		while (pending_distances.size() != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);
		if (mismatches == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule

@@ filelist.f @@
design/sssp_pkg.sv
design/sssp_ram.sv
design/sssp_relax.sv
design/single_source_shortest_path_core.sv
dv/tb_top.sv
